[design/svt_pkg.sv]
`default_nettype none

package svt_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  // broadcast to every cell in the update cycle
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [ValueW-1:0] value;
  } svt_op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     valid;
    logic                     at_pos;   // at or above the insert point
  } svt_link_t;

endpackage

`default_nettype wire

[design/svt_cell.sv]
`default_nettype none

module svt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  svt_pkg::svt_op_t  op_i,
  input  logic              found_i,
  input  svt_pkg::svt_link_t lo_i,
  input  svt_pkg::svt_link_t hi_i,
  output svt_pkg::svt_link_t link_o,
  output logic              eq_o
);
  import svt_pkg::*;

  logic signed [ValueW-1:0] value_q, value_d;
  logic                     valid_q, valid_d;
  logic                     op_lt_cell;
  logic                     cell_lt_op;
  logic                     at_pos;
  logic                     del_here;

  assign op_lt_cell = op_i.value < value_q;
  assign cell_lt_op = value_q < op_i.value;
  // insert point: first empty slot or first value strictly above the operand
  assign at_pos     = !valid_q || op_lt_cell;
  // delete point: first held value not below the operand (first copy)
  assign del_here   = valid_q && !cell_lt_op;

  assign eq_o   = valid_q && (value_q == op_i.value);
  assign link_o = '{value: value_q, valid: valid_q, at_pos: at_pos};

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (op_i.ins) begin
      valid_d = valid_q || lo_i.valid;
      if (at_pos) begin
        value_d = lo_i.at_pos ? lo_i.value : op_i.value;
      end
    end else if (op_i.del && found_i) begin
      valid_d = hi_i.valid;
      if (del_here) begin
        value_d = hi_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

[design/sorted_value_table.sv]
`default_nettype none

// Sorted value table: a multiset of up to Depth signed 32-bit values kept in
// ascending order in a row of cells. Each cell holds one value and a valid
// bit and talks only to its two neighbors, so an insert or a delete shifts
// the whole row at once.
//
// Command channel: a word (command_i, value_i) is taken on the rising edge
// where start is high and busy is low. Commands: insert, delete one copy,
// search. The row compares and shifts on that same edge.
//
// Result channel: in the cycle after acceptance done_o pulses for exactly one
// cycle with status_o, count_o, smallest_o and largest_o, all reflecting the
// table after the command. smallest/largest read 0 on an empty table.
// busy is high during that result cycle, so the table cannot take a new
// command while the result word of the last one is shown; that registered
// result cycle after the row update is what holds off the next command.
//
// The receiver cannot stall: the result word is shown once and is gone.
// Reset clears every valid bit and the count; the table comes up empty and
// ready to take a command on the first edge after reset is released.

module sorted_value_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        command_i,
  input  logic signed [svt_pkg::ValueW-1:0] value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [svt_pkg::CountW-1:0]        count_o,
  output logic signed [svt_pkg::ValueW-1:0] smallest_o,
  output logic signed [svt_pkg::ValueW-1:0] largest_o
);
  import svt_pkg::*;

  logic                  accept;
  logic                  busy_q;
  logic [CountW-1:0]     count_q, count_d;
  status_e               status_q, status_d;
  logic                  full, empty, found;
  svt_op_t               op;
  svt_link_t             links [Depth];
  logic [Depth-1:0]      eq_vec;
  logic [Depth-1:0]      valid_vec;
  logic signed [ValueW-1:0] largest;

  assign accept = start && !busy_q;
  assign busy   = busy_q;
  assign full   = (count_q == CountW'(Depth));
  assign empty  = (count_q == '0);
  assign found  = |eq_vec;

  // only an insert with room or a delete of a held value moves the row
  assign op.ins   = accept && (cmd_e'(command_i) == CMD_INSERT) && !full;
  assign op.del   = accept && (cmd_e'(command_i) == CMD_DELETE);
  assign op.value = value_i;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    svt_link_t lo, hi;
    if (i == 0) begin : g_lo_end
      assign lo = '{value: '0, valid: 1'b1, at_pos: 1'b0};
    end else begin : g_lo
      assign lo = links[i-1];
    end
    if (i == Depth - 1) begin : g_hi_end
      assign hi = '{value: '0, valid: 1'b0, at_pos: 1'b1};
    end else begin : g_hi
      assign hi = links[i+1];
    end

    svt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .found_i (found),
      .lo_i    (lo),
      .hi_i    (hi),
      .link_o  (links[i]),
      .eq_o    (eq_vec[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  // status and count for the accepted word
  always_comb begin
    status_d = STAT_OK;
    count_d  = count_q;
    case (cmd_e'(command_i))
      CMD_INSERT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else if (!found) begin
          status_d = STAT_NOTFOUND;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      CMD_SEARCH: status_d = found ? STAT_OK : STAT_NOTFOUND;
      default:    status_d = STAT_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      count_q  <= '0;
      status_q <= STAT_OK;
    end else begin
      busy_q <= accept;
      if (accept) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  // largest: the one valid cell whose upper neighbor is empty, or the top cell
  always_comb begin
    largest = '0;
    for (int i = 0; i < Depth; i++) begin
      if (valid_vec[i] && ((i == Depth - 1) || !valid_vec[(i + 1) % Depth])) begin
        largest = largest | links[i].value;
      end
    end
  end

  assign done_o     = busy_q;
  assign status_o   = status_q;
  assign count_o    = count_q;
  assign smallest_o = valid_vec[0] ? links[0].value : '0;
  assign largest_o  = largest;

  // held values always sit in the low slots, one per count
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("valid bits disagree with count");

  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid bits not packed at the bottom");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("count above depth");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result without an accepted word");

  a_sorted_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (smallest_o <= largest_o))
    else $error("smallest above largest");

endmodule

`default_nettype wire
